### design/gsa_pkg.sv
// Package for the generational slot allocator: defaults, codes and shared types.
package gsa_pkg;

    localparam int SLOTS_DEF = 512;
    localparam int KINDS_DEF = 4;

    localparam logic [31:0] GEN_INIT = 32'd1;

    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_READY = 2'd2;

    typedef enum logic [1:0] {
        OP_CREATE  = 2'd0,
        OP_DESTROY = 2'd1,
        OP_QUERY   = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CODE_OK     = 3'd0,
        CODE_FULL   = 3'd1,
        CODE_KIND   = 3'd2,
        CODE_INIT   = 3'd3,
        CODE_HANDLE = 3'd4
    } t_code;

    typedef enum logic [1:0] {
        S_SWEEP = 2'd0,
        S_IDLE  = 2'd1,
        S_SLOT  = 2'd2,
        S_EXEC  = 2'd3
    } t_state;

    typedef struct packed {
        logic accept;
        logic slot_rd;
        logic exec;
        logic sweep;
        logic wipe_kind;
        logic report;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
    } t_stat;

endpackage

### design/generational_slot_allocator_core.sv
// Top level of the generational slot allocator: controller, datapath and ports.
//
// Command channel: drive i_operation, i_res_kind, i_init_ok, i_slot_id and
// i_slot_gen with start high; the word is taken at the edge where busy is low.
// Result channel: o_strobe is high for exactly one cycle with o_status_code,
// o_out_id, o_out_gen and o_free_count; the receiver cannot hold it off.
// Sequencing: destroy and query read the slot memories at acceptance, then
// compare and, for destroy, write back in the execute state; create first
// reads the top of the free stack, and its entry then addresses the slot
// memories. busy is low again in the cycle the strobe is high, so the next
// word can be taken at the edge that takes the result word.
// Clear runs a sweep, one slot per cycle, over the generation, status and
// stack memories; its word follows the sweep.
// Reset (synchronous, active low) starts the same sweep, which also zeroes
// the stored kinds, with busy high and no result word.
module generational_slot_allocator_core #(
    parameter int SLOTS = gsa_pkg::SLOTS_DEF,
    parameter int KINDS = gsa_pkg::KINDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [2:0]  i_res_kind,
    input  logic        i_init_ok,
    input  logic [9:0]  i_slot_id,
    input  logic [31:0] i_slot_gen,
    output logic        o_strobe,
    output logic [2:0]  o_status_code,
    output logic [8:0]  o_out_id,
    output logic [31:0] o_out_gen,
    output logic [9:0]  o_free_count
);

    gsa_pkg::t_cmd  cmd;
    gsa_pkg::t_stat stat;

    gsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    gsa_dp #(
        .SLOTS(SLOTS),
        .KINDS(KINDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (i_operation),
        .i_res_kind    (i_res_kind),
        .i_init_ok     (i_init_ok),
        .i_slot_id     (i_slot_id),
        .i_slot_gen    (i_slot_gen),
        .o_strobe      (o_strobe),
        .o_status_code (o_status_code),
        .o_out_id      (o_out_id),
        .o_out_gen     (o_out_gen),
        .o_free_count  (o_free_count)
    );

endmodule

### design/gsa_ram.sv
// Generic simple dual-port RAM with registered read.
module gsa_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/gsa_ctrl.sv
// Controller state machine of the generational slot allocator.
module gsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_operation,
    input  gsa_pkg::t_stat i_stat,
    output gsa_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    gsa_pkg::t_state r_state, n_state;
    logic            r_wipe, n_wipe;
    logic            r_report, n_report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gsa_pkg::S_SWEEP;
            r_wipe   <= 1'b1;
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wipe   <= n_wipe;
            r_report <= n_report;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_wipe   = r_wipe;
        n_report = r_report;
        o_cmd    = '0;
        o_busy   = 1'b1;
        unique case (r_state)
            gsa_pkg::S_SWEEP: begin
                o_cmd.sweep     = 1'b1;
                o_cmd.wipe_kind = r_wipe;
                o_cmd.report    = r_report;
                if (i_stat.sweep_last) begin
                    n_state = gsa_pkg::S_IDLE;
                end
            end
            gsa_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    unique case (gsa_pkg::t_op'(i_operation)) inside
                        gsa_pkg::OP_CREATE: begin
                            n_state = gsa_pkg::S_SLOT;
                        end
                        gsa_pkg::OP_DESTROY, gsa_pkg::OP_QUERY: begin
                            n_state = gsa_pkg::S_EXEC;
                        end
                        default: begin
                            n_state  = gsa_pkg::S_SWEEP;
                            n_wipe   = 1'b0;
                            n_report = 1'b1;
                        end
                    endcase
                end
            end
            gsa_pkg::S_SLOT: begin
                o_cmd.slot_rd = 1'b1;
                n_state       = gsa_pkg::S_EXEC;
            end
            gsa_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = gsa_pkg::S_IDLE;
            end
            default: begin
                n_state = gsa_pkg::S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_exec_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gsa_pkg::S_EXEC) |=> (r_state == gsa_pkg::S_IDLE))
        else $error("execute state did not return to idle");
    a_slot_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gsa_pkg::S_SLOT) |=> (r_state == gsa_pkg::S_EXEC))
        else $error("slot read not followed by execute");
    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_operation == gsa_pkg::OP_CLEAR) |=>
        (r_state == gsa_pkg::S_SWEEP && r_report && !r_wipe))
        else $error("clear did not start a reporting sweep");
`endif

endmodule

### design/gsa_dp.sv
// Datapath of the generational slot allocator: slot memories, free stack and result word.
module gsa_dp #(
    parameter int SLOTS = gsa_pkg::SLOTS_DEF,
    parameter int KINDS = gsa_pkg::KINDS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gsa_pkg::t_cmd  i_cmd,
    output gsa_pkg::t_stat o_stat,
    input  logic [1:0]     i_operation,
    input  logic [2:0]     i_res_kind,
    input  logic           i_init_ok,
    input  logic [9:0]     i_slot_id,
    input  logic [31:0]    i_slot_gen,
    output logic           o_strobe,
    output logic [2:0]     o_status_code,
    output logic [8:0]     o_out_id,
    output logic [31:0]    o_out_gen,
    output logic [9:0]     o_free_count
);

    localparam int IW  = $clog2(SLOTS);
    localparam int DW  = $clog2(SLOTS + 1);
    localparam int IDW = (IW > 10) ? IW : 10;

    logic [1:0]    r_op;
    logic [2:0]    r_kind;
    logic          r_init;
    logic [31:0]   r_gen;
    logic          r_in_range;
    logic [IW-1:0] r_slot;
    logic [IW-1:0] r_cnt;
    logic [DW-1:0] r_depth, n_depth;

    logic          r_strobe;
    logic [2:0]    r_code;
    logic [8:0]    r_id;
    logic [31:0]   r_ogen;
    logic [9:0]    r_free;

    logic [IDW-1:0] id_w;
    logic [DW-1:0]  depth_m1;
    logic           sweep_last;

    logic           slot_re;
    logic [IW-1:0]  slot_raddr;
    logic [31:0]    gen_q;
    logic [1:0]     status_q;
    logic [1:0]     kind_q;
    logic [IW-1:0]  stack_q;

    logic           gen_we, status_we, kind_we, stack_we;
    logic [IW-1:0]  gen_wa, status_wa, kind_wa, stack_wa;
    logic [31:0]    gen_wd;
    logic [1:0]     status_wd, kind_wd;
    logic [IW-1:0]  stack_wd;

    gsa_pkg::t_code code;
    logic [8:0]     res_id;
    logic [31:0]    res_gen;
    logic           gen_hit;

    assign id_w       = IDW'(i_slot_id);
    assign depth_m1   = r_depth - DW'(1);
    assign sweep_last = (r_cnt == IW'(SLOTS - 1));
    assign o_stat.sweep_last = sweep_last;

    assign slot_re    = i_cmd.accept | i_cmd.slot_rd;
    assign slot_raddr = i_cmd.slot_rd ? stack_q : id_w[IW-1:0];
    assign gen_hit    = (gen_q == r_gen);

    gsa_ram #(.W(32), .D(SLOTS)) u_gen (
        .i_clk(i_clk), .i_we(gen_we), .i_waddr(gen_wa), .i_wdata(gen_wd),
        .i_re(slot_re), .i_raddr(slot_raddr), .o_rdata(gen_q)
    );

    gsa_ram #(.W(2), .D(SLOTS)) u_status (
        .i_clk(i_clk), .i_we(status_we), .i_waddr(status_wa), .i_wdata(status_wd),
        .i_re(slot_re), .i_raddr(slot_raddr), .o_rdata(status_q)
    );

    gsa_ram #(.W(2), .D(SLOTS)) u_kind (
        .i_clk(i_clk), .i_we(kind_we), .i_waddr(kind_wa), .i_wdata(kind_wd),
        .i_re(slot_re), .i_raddr(slot_raddr), .o_rdata(kind_q)
    );

    gsa_ram #(.W(IW), .D(SLOTS)) u_stack (
        .i_clk(i_clk), .i_we(stack_we), .i_waddr(stack_wa), .i_wdata(stack_wd),
        .i_re(i_cmd.accept), .i_raddr(depth_m1[IW-1:0]), .o_rdata(stack_q)
    );

    always_comb begin
        gen_we    = 1'b0;
        gen_wa    = r_slot;
        gen_wd    = gen_q + 32'd1;
        status_we = 1'b0;
        status_wa = r_slot;
        status_wd = gsa_pkg::ST_EMPTY;
        kind_we   = 1'b0;
        kind_wa   = r_slot;
        kind_wd   = r_kind[1:0];
        stack_we  = 1'b0;
        stack_wa  = r_depth[IW-1:0];
        stack_wd  = r_slot;
        n_depth   = r_depth;
        code      = gsa_pkg::CODE_OK;
        res_id    = 9'd0;
        res_gen   = 32'd0;
        if (i_cmd.sweep) begin
            gen_we    = 1'b1;
            gen_wa    = r_cnt;
            gen_wd    = gsa_pkg::GEN_INIT;
            status_we = 1'b1;
            status_wa = r_cnt;
            kind_we   = i_cmd.wipe_kind;
            kind_wa   = r_cnt;
            kind_wd   = 2'd0;
            stack_we  = 1'b1;
            stack_wa  = r_cnt;
            stack_wd  = r_cnt;
            if (sweep_last) begin
                n_depth = DW'(SLOTS);
            end
        end else if (i_cmd.exec) begin
            case (gsa_pkg::t_op'(r_op))
                gsa_pkg::OP_CREATE: begin
                    if (r_depth == '0) begin
                        code = gsa_pkg::CODE_FULL;
                    end else if ({1'b0, r_kind} >= 4'(KINDS)) begin
                        code = gsa_pkg::CODE_KIND;
                    end else begin
                        kind_we   = 1'b1;
                        status_we = 1'b1;
                        if (!r_init) begin
                            code = gsa_pkg::CODE_INIT;
                        end else begin
                            status_wd = gsa_pkg::ST_READY;
                            n_depth   = depth_m1;
                            res_id    = 9'(r_slot);
                            res_gen   = gen_q;
                        end
                    end
                end
                gsa_pkg::OP_DESTROY: begin
                    if (!r_in_range || !gen_hit || status_q != gsa_pkg::ST_READY) begin
                        code = gsa_pkg::CODE_HANDLE;
                    end else begin
                        gen_we    = 1'b1;
                        status_we = 1'b1;
                        if (r_depth < DW'(SLOTS)) begin
                            stack_we = 1'b1;
                            n_depth  = r_depth + DW'(1);
                        end
                    end
                end
                gsa_pkg::OP_QUERY: begin
                    if (!r_in_range || !gen_hit || {1'b0, kind_q} != r_kind) begin
                        code = gsa_pkg::CODE_HANDLE;
                    end
                end
                default: begin
                    code = gsa_pkg::CODE_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op       <= i_operation;
            r_kind     <= i_res_kind;
            r_init     <= i_init_ok;
            r_gen      <= i_slot_gen;
            r_in_range <= ({1'b0, id_w} < (IDW + 1)'(SLOTS));
        end
        if (slot_re) begin
            r_slot <= slot_raddr;
        end
        r_code <= code;
        r_id   <= res_id;
        r_ogen <= res_gen;
        r_free <= 10'(n_depth);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_depth  <= DW'(SLOTS);
            r_strobe <= 1'b0;
        end else begin
            r_depth  <= n_depth;
            r_strobe <= i_cmd.exec | (i_cmd.sweep & i_cmd.report & sweep_last);
            if (i_cmd.sweep) begin
                r_cnt <= sweep_last ? '0 : r_cnt + IW'(1);
            end
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status_code = r_code;
    assign o_out_id      = r_id;
    assign o_out_gen     = r_ogen;
    assign o_free_count  = r_free;

`ifndef ASSERT_OFF
    a_depth_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(SLOTS))
        else $error("free stack depth above slot count");
    a_exec_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_strobe)
        else $error("execute gave no result word");
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe held for two cycles");
    a_pop_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == gsa_pkg::OP_CREATE && code == gsa_pkg::CODE_OK) |=>
        (r_depth == $past(r_depth) - DW'(1)))
        else $error("successful create did not pop one slot");
`endif

endmodule
